[src/wbps_pkg.sv]
package wbps_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int ADDR_WIDTH  = 48;
  localparam int PAT_BYTES   = 16;
  localparam int LIMIT_MAX   = 16;
  localparam int LEN_CAP     = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

  localparam int LEN_W     = 5;
  localparam int FILL_W    = $clog2(PATTERN_MAX + 1);
  localparam int WIN_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  localparam logic [2:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [2:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [2:0] REG_CARE_MASK      = 3'd2;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [2:0] REG_MATCH_LIMIT    = 3'd4;
  localparam logic [2:0] REG_ADDR_BIAS      = 3'd5;

  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [1:0] STATUS_NONE      = 2'd0;
  localparam logic [1:0] STATUS_UNIQUE    = 2'd1;
  localparam logic [1:0] STATUS_AMBIGUOUS = 2'd2;

  typedef struct packed {
    logic [63:0]      pattern_low;
    logic [63:0]      pattern_high;
    logic [15:0]      care_mask;
    logic [LEN_W-1:0] pattern_length;
    logic [LEN_W-1:0] match_limit;
    logic [15:0]      addr_bias;
  } cfg_t;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic [ADDR_WIDTH-1:0] byte_addr;
    logic                  span_start;
    logic                  end_of_scan;
  } item_t;

  typedef struct packed {
    logic                  kind;
    logic [ADDR_WIDTH-1:0] match_addr;
    logic [LEN_W-1:0]      match_number;
    logic [1:0]            status;
    logic                  last;
  } res_t;

endpackage

[src/wbps_core.sv]
module wbps_core
  import wbps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        item_v,
  input  item_t       item,
  output logic [1:0]  res_cnt,
  output res_t        res [2]
);

  logic [7:0]            win_r    [PATTERN_MAX];
  logic [7:0]            win_nxt  [PATTERN_MAX];
  logic [FILL_W-1:0]     fill_r, fill_nxt, fill_base;
  logic [LEN_W-1:0]      count_r, count_nxt, count_inc;
  logic [ADDR_WIDTH-1:0] first_r, first_nxt;
  logic [LEN_W-1:0]      len, lim;
  logic [8*PAT_BYTES-1:0] pat;
  logic                  cmp_ok, hit;
  logic [ADDR_WIDTH-1:0] start_addr, verdict_addr;
  logic [1:0]            verdict_status;
  res_t                  rpt, vrd;
  int                    age;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (int'(cfg.pattern_length) > LEN_CAP) begin
      len = LEN_W'(LEN_CAP);
    end else begin
      len = cfg.pattern_length;
    end
    if (cfg.match_limit == '0) begin
      lim = LEN_W'(1);
    end else if (int'(cfg.match_limit) > LIMIT_MAX) begin
      lim = LEN_W'(LIMIT_MAX);
    end else begin
      lim = cfg.match_limit;
    end
  end

  always_comb begin
    win_nxt[0] = item.data_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_nxt[i] = item.span_start ? 8'h00 : win_r[i-1];
    end
    fill_base = item.span_start ? '0 : fill_r;
    fill_nxt  = (int'(fill_base) == PATTERN_MAX) ? fill_base : fill_base + FILL_W'(1);
  end

  assign pat = {cfg.pattern_high, cfg.pattern_low};

  always_comb begin
    cmp_ok = 1'b1;
    age    = 0;
    for (int k = 0; k < PAT_BYTES; k++) begin
      age = int'(len) - 1 - k;
      if (k < int'(len) && cfg.care_mask[k] &&
          win_nxt[WIN_IDX_W'(age)] != pat[8*k +: 8]) begin
        cmp_ok = 1'b0;
      end
    end
  end

  always_comb begin
    hit        = cmp_ok && (int'(fill_nxt) >= int'(len)) && (count_r < lim);
    start_addr = item.byte_addr - ADDR_WIDTH'(len - LEN_W'(1));
    count_inc  = count_r + LEN_W'(1);
    count_nxt  = hit ? count_inc : count_r;
    first_nxt  = (hit && count_r == '0) ? start_addr : first_r;

    verdict_addr = '0;
    if (count_nxt == '0) begin
      verdict_status = STATUS_NONE;
    end else if (count_nxt == LEN_W'(1)) begin
      verdict_status = STATUS_UNIQUE;
      verdict_addr   = first_nxt + ADDR_WIDTH'(cfg.addr_bias);
    end else begin
      verdict_status = STATUS_AMBIGUOUS;
    end

    rpt.kind         = KIND_REPORT;
    rpt.match_addr   = start_addr;
    rpt.match_number = count_nxt;
    rpt.status       = STATUS_NONE;
    rpt.last         = !item.end_of_scan;

    vrd.kind         = KIND_VERDICT;
    vrd.match_addr   = verdict_addr;
    vrd.match_number = count_nxt;
    vrd.status       = verdict_status;
    vrd.last         = 1'b1;

    res[0]  = hit ? rpt : vrd;
    res[1]  = vrd;
    res_cnt = item_v ? (2'(hit) + 2'(item.end_of_scan)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      count_r <= '0;
      first_r <= '0;
    end else if (item_v) begin
      if (item.end_of_scan) begin
        fill_r  <= '0;
        count_r <= '0;
        first_r <= '0;
      end else begin
        fill_r  <= fill_nxt;
        count_r <= count_nxt;
        first_r <= first_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_v) begin
      win_r <= win_nxt;
    end
  end

endmodule

[src/wbps_outq.sv]
module wbps_outq
  import wbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            push_cnt,
  input  res_t                  push_data [2],
  input  logic                  pop,
  output res_t                  head,
  output logic [OUTQ_CNT_W-1:0] level
);

  res_t                  mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wp_r, rp_r, wp_next1;
  logic [OUTQ_CNT_W-1:0] level_r;

  assign wp_next1 = wp_r + OUTQ_PTR_W'(1);
  assign head     = mem[rp_r];
  assign level    = level_r;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wp_r] <= push_data[0];
    end
    if (push_cnt == 2'd2) begin
      mem[wp_next1] <= push_data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_r + OUTQ_PTR_W'(push_cnt);
      rp_r    <= rp_r + OUTQ_PTR_W'(pop);
      level_r <= level_r + OUTQ_CNT_W'(push_cnt) - OUTQ_CNT_W'(pop);
    end
  end

endmodule

[src/wildcard_byte_pattern_scanner_top.sv]
// Channel  Direction  Ports                                                   Handshake
// in       input      in_data_byte in_byte_addr in_span_start in_end_of_scan  in_valid/in_stall
// out      output     out_kind out_match_addr out_match_number out_status     out_valid/out_stall
//                     out_last
// cfg      input      cfg_psel cfg_penable cfg_pwrite cfg_paddr cfg_pwdata    APB, cfg_pready
//
// One byte per cycle unless in_stall is high: a beat is registered, matched against the
// window in the next cycle and its results (at most two) land in an eight-entry result queue.
// A beat passes through the stage register, and its results through the result queue, before they can be taken.
// in_stall rises when the queue cannot take the results of the beat in flight plus one more.
// Reset (rst_n low, synchronous) empties the queue and the scan state and restores registers.
module wildcard_byte_pattern_scanner_top
  import wbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic [ADDR_WIDTH-1:0] in_byte_addr,
  input  logic                  in_span_start,
  input  logic                  in_end_of_scan,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [ADDR_WIDTH-1:0] out_match_addr,
  output logic [LEN_W-1:0]      out_match_number,
  output logic [1:0]            out_status,
  output logic                  out_last,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t                  cfg_r;
  logic [2:0]            reg_idx;
  logic                  cfg_wr;
  logic                  stage_v_r;
  item_t                 stage_r;
  logic                  in_acc;
  logic [1:0]            res_cnt;
  res_t                  res [2];
  res_t                  head;
  logic [OUTQ_CNT_W-1:0] level;
  logic                  pop;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.care_mask      <= '0;
      cfg_r.pattern_length <= LEN_W'(1);
      cfg_r.match_limit    <= LEN_W'(LIMIT_MAX);
      cfg_r.addr_bias      <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PATTERN_LOW:    cfg_r.pattern_low    <= cfg_pwdata;
        REG_PATTERN_HIGH:   cfg_r.pattern_high   <= cfg_pwdata;
        REG_CARE_MASK:      cfg_r.care_mask      <= cfg_pwdata[15:0];
        REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_pwdata[LEN_W-1:0];
        REG_MATCH_LIMIT:    cfg_r.match_limit    <= cfg_pwdata[LEN_W-1:0];
        REG_ADDR_BIAS:      cfg_r.addr_bias      <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LOW:    cfg_prdata = cfg_r.pattern_low;
      REG_PATTERN_HIGH:   cfg_prdata = cfg_r.pattern_high;
      REG_CARE_MASK:      cfg_prdata = CFG_DATA_W'(cfg_r.care_mask);
      REG_PATTERN_LENGTH: cfg_prdata = CFG_DATA_W'(cfg_r.pattern_length);
      REG_MATCH_LIMIT:    cfg_prdata = CFG_DATA_W'(cfg_r.match_limit);
      REG_ADDR_BIAS:      cfg_prdata = CFG_DATA_W'(cfg_r.addr_bias);
      default:            cfg_prdata = '0;
    endcase
  end

  assign in_stall = (int'(level) + (stage_v_r ? 2 : 0)) > (OUTQ_DEPTH - 2);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage_r.data_byte   <= in_data_byte;
      stage_r.byte_addr   <= in_byte_addr;
      stage_r.span_start  <= in_span_start;
      stage_r.end_of_scan <= in_end_of_scan;
    end
  end

  wbps_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .item_v  (stage_v_r),
    .item    (stage_r),
    .res_cnt (res_cnt),
    .res     (res)
  );

  assign out_valid = (level != '0);
  assign pop       = out_valid && !out_stall;

  wbps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (res_cnt),
    .push_data (res),
    .pop       (pop),
    .head      (head),
    .level     (level)
  );

  assign out_kind         = head.kind;
  assign out_match_addr   = head.match_addr;
  assign out_match_number = head.match_number;
  assign out_status       = head.status;
  assign out_last         = head.last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(level) <= OUTQ_DEPTH)
    else $error("result queue overflow");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_VERDICT |-> out_last)
    else $error("verdict beat without last");

  a_report_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REPORT |-> out_status == STATUS_NONE &&
    out_match_number != '0)
    else $error("bad match report");

  a_unique_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_VERDICT && out_status == STATUS_UNIQUE |->
    out_match_number == LEN_W'(1))
    else $error("unique verdict with count other than one");
`endif

endmodule

[sim/wildcard_byte_pattern_scanner_top_tb.sv]
module wildcard_byte_pattern_scanner_top_tb import wbps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int PHASES         = 10;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte   = '0;
  logic [ADDR_WIDTH-1:0] in_byte_addr   = '0;
  logic                  in_span_start  = 1'b0;
  logic                  in_end_of_scan = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic                  out_kind;
  logic [ADDR_WIDTH-1:0] out_match_addr;
  logic [LEN_W-1:0]      out_match_number;
  logic [1:0]            out_status;
  logic                  out_last;
  logic                  cfg_psel       = 1'b0;
  logic                  cfg_penable    = 1'b0;
  logic                  cfg_pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr      = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata     = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  wildcard_byte_pattern_scanner_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_byte_addr     (in_byte_addr),
    .in_span_start    (in_span_start),
    .in_end_of_scan   (in_end_of_scan),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_match_addr   (out_match_addr),
    .out_match_number (out_match_number),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t byte_stream[$];
  res_t  due_results[$];
  int    error_count     = 0;
  int    sender_idle_pct = 0;
  int    recv_stall_pct  = 0;
  int    quiet_cycles    = 0;

  cfg_t                  regs_mirror;
  logic [7:0]            scan_window [PATTERN_MAX];
  int                    scan_fill;
  int                    hit_count;
  logic [ADDR_WIDTH-1:0] first_hit_addr;

  logic [ADDR_WIDTH-1:0] gen_addr;
  bit                    gen_fresh;
  bit                    gen_end;
  int                    gen_made;

  wire beat_in  = in_valid && !in_stall;
  wire beat_out = out_valid && !out_stall;

  function automatic int eff_len();
    if (regs_mirror.pattern_length == 0) return 1;
    if (regs_mirror.pattern_length > LEN_CAP) return LEN_CAP;
    return int'(regs_mirror.pattern_length);
  endfunction

  function automatic logic [7:0] pattern_byte(input int k);
    logic [127:0] pat;
    pat = {regs_mirror.pattern_high, regs_mirror.pattern_low};
    return pat[8*k +: 8];
  endfunction

  task automatic clear_window();
    foreach (scan_window[i]) scan_window[i] = 8'h00;
    scan_fill = 0;
  endtask

  task automatic scan_byte(input item_t it);
    int                    len;
    int                    lim;
    bit                    hit;
    logic [ADDR_WIDTH-1:0] start_addr;
    res_t                  r;
    len = eff_len();
    if (regs_mirror.match_limit == 0) lim = 1;
    else if (regs_mirror.match_limit > LIMIT_MAX) lim = LIMIT_MAX;
    else lim = int'(regs_mirror.match_limit);
    if (it.span_start) clear_window();
    for (int i = PATTERN_MAX - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
    scan_window[0] = it.data_byte;
    if (scan_fill < PATTERN_MAX) scan_fill++;
    if (scan_fill >= len && hit_count < lim) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (regs_mirror.care_mask[k] && scan_window[len-1-k] != pattern_byte(k)) hit = 1'b0;
      end
      if (hit) begin
        start_addr = it.byte_addr - ADDR_WIDTH'(len - 1);
        if (hit_count == 0) first_hit_addr = start_addr;
        hit_count++;
        r.kind         = KIND_REPORT;
        r.match_addr   = start_addr;
        r.match_number = LEN_W'(hit_count);
        r.status       = STATUS_NONE;
        r.last         = !it.end_of_scan;
        due_results.insert(due_results.size(), r);
      end
    end
    if (it.end_of_scan) begin
      r.kind         = KIND_VERDICT;
      r.match_addr   = '0;
      r.match_number = LEN_W'(hit_count);
      r.last         = 1'b1;
      if (hit_count == 0) begin
        r.status = STATUS_NONE;
      end else if (hit_count == 1) begin
        r.status     = STATUS_UNIQUE;
        r.match_addr = first_hit_addr + ADDR_WIDTH'(regs_mirror.addr_bias);
      end else begin
        r.status = STATUS_AMBIGUOUS;
      end
      due_results.insert(due_results.size(), r);
      clear_window();
      hit_count      = 0;
      first_hit_addr = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [ADDR_WIDTH-1:0] want,
                             input logic [ADDR_WIDTH-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Driver: advance on accept, hold while stalled
  always @(posedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (beat_in) scan_byte(item_t'({in_data_byte, in_byte_addr, in_span_start, in_end_of_scan}));
      if (!in_valid || !in_stall) begin
        if (byte_stream.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = byte_stream.pop_front();
          in_valid       <= 1'b1;
          in_data_byte   <= nxt.data_byte;
          in_byte_addr   <= nxt.byte_addr;
          in_span_start  <= nxt.span_start;
          in_end_of_scan <= nxt.end_of_scan;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    res_t want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && beat_out) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0h addr %0h num %0h",
                 $time, out_kind, out_match_addr, out_match_number);
        error_count++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", ADDR_WIDTH'(want.kind), ADDR_WIDTH'(out_kind));
        check_field("match_addr", want.match_addr, out_match_addr);
        check_field("match_number", ADDR_WIDTH'(want.match_number),
                    ADDR_WIDTH'(out_match_number));
        check_field("status", ADDR_WIDTH'(want.status), ADDR_WIDTH'(out_status));
        check_field("last", ADDR_WIDTH'(want.last), ADDR_WIDTH'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || beat_in || beat_out || cfg_psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:    regs_mirror.pattern_low    = val;
      REG_PATTERN_HIGH:   regs_mirror.pattern_high   = val;
      REG_CARE_MASK:      regs_mirror.care_mask      = val[15:0];
      REG_PATTERN_LENGTH: regs_mirror.pattern_length = val[LEN_W-1:0];
      REG_MATCH_LIMIT:    regs_mirror.match_limit    = val[LEN_W-1:0];
      REG_ADDR_BIAS:      regs_mirror.addr_bias      = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input cfg_t c);
    write_reg(REG_PATTERN_LOW, c.pattern_low);
    write_reg(REG_PATTERN_HIGH, c.pattern_high);
    write_reg(REG_CARE_MASK, CFG_DATA_W'(c.care_mask));
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(c.pattern_length));
    write_reg(REG_MATCH_LIMIT, CFG_DATA_W'(c.match_limit));
    write_reg(REG_ADDR_BIAS, CFG_DATA_W'(c.addr_bias));
  endtask

  task automatic wait_drained();
    while (byte_stream.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic push_item(input logic [7:0] b, input logic [ADDR_WIDTH-1:0] a,
                           input bit start, input bit fin);
    item_t it;
    it.data_byte   = b;
    it.byte_addr   = a;
    it.span_start  = start;
    it.end_of_scan = fin;
    byte_stream.insert(byte_stream.size(), it);
    gen_made++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(b, gen_addr, gen_fresh, gen_end);
    gen_addr++;
    gen_fresh = 1'b0;
    gen_end   = 1'b0;
  endtask

  function automatic logic [ADDR_WIDTH-1:0] span_base();
    case ($urandom_range(7))
      0:       return '0;
      1:       return {{(ADDR_WIDTH-4){1'b1}}, 4'h8};
      default: return ADDR_WIDTH'({$urandom, $urandom});
    endcase
  endfunction

  // Mostly planted occurrences inside spans; some broken ones, filler and noise
  task automatic compose_stream(input int n_items, input bit close_scan);
    int         len;
    int         corrupt;
    int         pick;
    logic [7:0] b;
    gen_made  = 0;
    gen_addr  = span_base();
    gen_fresh = 1'b1;
    gen_end   = 1'b0;
    while (gen_made < n_items) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len     = eff_len();
        corrupt = ($urandom_range(5) == 0) ? $urandom_range(len - 1) : -1;
        for (int k = 0; k < len; k++) begin
          b = regs_mirror.care_mask[k] ? pattern_byte(k) : 8'($urandom);
          if (k == corrupt) b = b ^ 8'($urandom_range(255, 1));
          push_byte(b);
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(6, 1)) push_byte(8'($urandom));
      end else if (pick < 92) begin
        gen_addr  = span_base();
        gen_fresh = 1'b1;
      end else if (pick < 96) begin
        gen_end = 1'b1;
      end else begin
        push_item(8'($urandom), ADDR_WIDTH'({$urandom, $urandom}),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
    if (close_scan) begin
      gen_end = 1'b1;
      push_byte(8'($urandom));
    end
  endtask

  initial begin
    cfg_t settings;
    int   len_plan [PHASES];
    int   lim_plan [PHASES];
    len_plan                   = '{16, 1, 31, 2, 5, 0, 16, 8, 3, 12};
    lim_plan                   = '{16, 1, 20, 3, 16, 0, 2, 16, 5, 16};
    regs_mirror                = '0;
    regs_mirror.pattern_length = LEN_W'(1);
    regs_mirror.match_limit    = LEN_W'(LIMIT_MAX);
    clear_window();
    hit_count       = 0;
    first_hit_addr  = '0;
    sender_idle_pct = 6;
    recv_stall_pct  = 82;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one-byte wildcard pattern, every byte matches
    push_item(8'h00, '0, 1'b1, 1'b0);
    push_item(8'hFF, '1, 1'b0, 1'b0);
    push_item(8'h5A, ADDR_WIDTH'(1), 1'b0, 1'b1);
    push_item(8'hAA, ADDR_WIDTH'(48'h1234_5678_9ABC), 1'b1, 1'b1);
    wait_drained();

    // full-length full-care pattern, limit of one, report from the final byte
    settings.pattern_low    = '1;
    settings.pattern_high   = '0;
    settings.care_mask      = 16'hFFFF;
    settings.pattern_length = LEN_W'(16);
    settings.match_limit    = LEN_W'(1);
    settings.addr_bias      = 16'hFFFF;
    write_all(settings);
    gen_addr  = '0;
    gen_fresh = 1'b1;
    gen_end   = 1'b0;
    repeat (8) push_byte(8'hFF);
    repeat (7) push_byte(8'h00);
    gen_end = 1'b1;
    push_byte(8'h00);
    wait_drained();

    // writes past the register map are dropped
    write_reg(3'd6, '1);
    write_reg(3'd7, '1);
    // zero length and zero limit act as one
    settings.care_mask      = 16'h0000;
    settings.pattern_length = '0;
    settings.match_limit    = '0;
    write_all(settings);
    push_item(8'h00, '0, 1'b1, 1'b0);
    push_item(8'hFF, ADDR_WIDTH'(1), 1'b0, 1'b1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        sender_idle_pct = 6;
        recv_stall_pct  = 82;
      end else if (p < 7) begin
        sender_idle_pct = 82;
        recv_stall_pct  = 6;
      end else begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
      settings.pattern_low    = {$urandom, $urandom};
      settings.pattern_high   = {$urandom, $urandom};
      settings.pattern_length = LEN_W'(len_plan[p]);
      settings.match_limit    = LEN_W'(lim_plan[p]);
      if (p == 0 || p == 2) settings.care_mask = 16'hFFFF;
      else if (p == 1) settings.care_mask = 16'h0000;
      else settings.care_mask = 16'($urandom | $urandom);
      if (p == 0) settings.addr_bias = 16'hFFFF;
      else if (p == 1) settings.addr_bias = 16'h0000;
      else settings.addr_bias = 16'($urandom);
      write_all(settings);
      // leave the scan open once so the next phase lowers the limit below the count
      compose_stream(PHASE_ITEMS, p != 4);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[wildcard_byte_pattern_scanner_top.f]
src/wbps_pkg.sv
src/wbps_core.sv
src/wbps_outq.sv
src/wildcard_byte_pattern_scanner_top.sv
sim/wildcard_byte_pattern_scanner_top_tb.sv
